FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, off while rst_n is low
`define DGNL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form of the above
`define DGNL_ASSERT_IMP(label, cond, expr, msg) \
  `DGNL_ASSERT(label, (cond) |-> (expr), msg)

`endif

FILE: hw/rtl/dgnl_pkg.sv
package dgnl_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_DEPTH_BITS = 16;

  localparam int IN_DEPTH_W  = 16;
  localparam int PIX_IDX_W   = 20;
  localparam int CFG_SIZE_W  = 11;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int LINK_FACTOR  = 20;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

endpackage

FILE: hw/rtl/dgnl_in_if.sv
interface dgnl_in_if
  import dgnl_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [IN_DEPTH_W-1:0] depth;

  modport source (output valid, output depth, input ready);
  modport sink (input valid, input depth, output ready);
endinterface

FILE: hw/rtl/dgnl_out_if.sv
interface dgnl_out_if
  import dgnl_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [PIX_IDX_W-1:0] pixel_index;
  logic                 link_left;
  logic                 link_up;
  logic                 end_of_frame;

  modport source (output valid, output pixel_index, output link_left, output link_up,
                  output end_of_frame, input ready);
  modport sink (input valid, input pixel_index, input link_left, input link_up,
                input end_of_frame, output ready);
endinterface

FILE: hw/rtl/depth_grid_neighbour_links_core.sv
// channel   dir  payload                                         handshake
// in_chan   in   depth[15:0]                                     valid/ready
// out_chan  out  pixel_index[19:0] link_left link_up end_of_frame valid/ready
// apb       in   frame_width (0x0), frame_height (0x4)           psel/penable
//
// one item per cycle while out_chan is ready; link stage feeds output register
// the line store is one read and one write port, read and written at the same
// column on accept, so a row-to-row access never collides
// rst_n is synchronous; counters and sizes return to reset values, line store
// is not cleared and is read on every accept, used for link_up only past row 0
// a stall on out_chan fills the link stage, then drops in_chan.ready
module depth_grid_neighbour_links_core
  import dgnl_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int DEPTH_BITS = DEF_DEPTH_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dgnl_in_if.sink               in_chan,
  dgnl_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [CFG_SIZE_W-1:0] frame_width_r;
  logic [CFG_SIZE_W-1:0] frame_height_r;
  logic                  cfg_wr;

  logic [COL_W:0] w_eff;
  logic [ROW_W:0] h_eff;

  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [PIX_IDX_W-1:0] idx_r, idx_nxt;
  logic [COL_W:0]       col_ext, col_inc;
  logic [ROW_W:0]       row_ext;
  logic [PIX_IDX_W-1:0] idx_cur;
  logic                 eof_cur;

  logic [DEPTH_BITS-1:0] depth_in;
  logic [DEPTH_BITS-1:0] prev_depth_r;
  logic [DEPTH_BITS-1:0] line_mem [MAX_WIDTH];
  logic [DEPTH_BITS-1:0] mem_rd_r;

  logic                  in_fire;
  logic                  s1_adv;
  logic                  s1_valid_r;
  logic [DEPTH_BITS-1:0] s1_depth_r;
  logic [DEPTH_BITS-1:0] s1_prev_r;
  logic                  s1_has_left_r;
  logic                  s1_has_up_r;
  logic [PIX_IDX_W-1:0]  s1_idx_r;
  logic                  s1_eof_r;
  logic                  left_hit;
  logic                  up_hit;

  logic                 out_valid_r;
  logic [PIX_IDX_W-1:0] out_idx_r;
  logic                 out_left_r;
  logic                 out_up_r;
  logic                 out_eof_r;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_SIZE_W'(WIDTH_RESET);
      frame_height_r <= CFG_SIZE_W'(HEIGHT_RESET);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[CFG_SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  always_comb begin
    if (frame_width_r < CFG_SIZE_W'(2)) begin
      w_eff = (COL_W+1)'(2);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_W+1)'(frame_width_r);
    end
    if (frame_height_r < CFG_SIZE_W'(2)) begin
      h_eff = (ROW_W+1)'(2);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (ROW_W+1)'(frame_height_r);
    end
  end

  // handshake and position of the incoming item
  assign depth_in = DEPTH_BITS'(in_chan.depth);
  assign s1_adv   = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_chan.valid && in_chan.ready;

  always_comb begin
    col_ext = {1'b0, col_r};
    row_ext = {1'b0, row_r};
    idx_cur = idx_r;
    if (col_ext >= w_eff) begin
      col_ext = '0;
      row_ext = row_ext + 1'b1;
    end
    if (row_ext >= h_eff) begin
      row_ext = '0;
      col_ext = '0;
      idx_cur = '0;
    end
    eof_cur = (col_ext == w_eff - 1'b1) && (row_ext == h_eff - 1'b1);
    col_inc = col_ext + 1'b1;
    if (eof_cur) begin
      col_nxt = '0;
      row_nxt = '0;
      idx_nxt = '0;
    end else if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_ext[ROW_W-1:0] + 1'b1;
      idx_nxt = idx_cur + 1'b1;
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_ext[ROW_W-1:0];
      idx_nxt = idx_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      idx_r        <= '0;
      prev_depth_r <= '0;
    end else if (in_fire) begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      idx_r        <= idx_nxt;
      prev_depth_r <= depth_in;
    end
  end

  // line store, read of the old entry and write of the new one in the same cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_rd_r                        <= line_mem[col_ext[COL_W-1:0]];
      line_mem[col_ext[COL_W-1:0]]    <= depth_in;
    end
  end

  // link stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_depth_r    <= depth_in;
      s1_prev_r     <= prev_depth_r;
      s1_has_left_r <= (col_ext != '0);
      s1_has_up_r   <= (row_ext != '0);
      s1_idx_r      <= idx_cur;
      s1_eof_r      <= eof_cur;
    end
  end

  dgnl_link #(.DEPTH_BITS(DEPTH_BITS)) u_link_left (
    .a      (s1_depth_r),
    .b      (s1_prev_r),
    .linked (left_hit)
  );

  dgnl_link #(.DEPTH_BITS(DEPTH_BITS)) u_link_up (
    .a      (s1_depth_r),
    .b      (mem_rd_r),
    .linked (up_hit)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_idx_r  <= s1_idx_r;
      out_left_r <= s1_has_left_r && left_hit;
      out_up_r   <= s1_has_up_r && up_hit;
      out_eof_r  <= s1_eof_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pixel_index  = out_idx_r;
  assign out_chan.link_left    = out_left_r;
  assign out_chan.link_up      = out_up_r;
  assign out_chan.end_of_frame = out_eof_r;

endmodule

FILE: hw/rtl/dgnl_link.sv
module dgnl_link
  import dgnl_pkg::*;
#(
  parameter int DEPTH_BITS = DEF_DEPTH_BITS
) (
  input  logic [DEPTH_BITS-1:0] a,
  input  logic [DEPTH_BITS-1:0] b,
  output logic                  linked
);

  localparam int PW = DEPTH_BITS + 5;

  logic [DEPTH_BITS-1:0] diff;
  logic [DEPTH_BITS:0]   sum;
  logic [PW-1:0]         scaled;

  always_comb begin
    diff   = (a > b) ? (a - b) : (b - a);
    sum    = {1'b0, a} + {1'b0, b};
    scaled = PW'(diff) * PW'(LINK_FACTOR);
    linked = (a != '0) && (b != '0) && (scaled <= PW'(sum));
  end

endmodule

FILE: hw/rtl/dgnl_checker.sv
`include "assert_macros.svh"

module dgnl_checker
  import dgnl_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [PIX_IDX_W-1:0] pixel_index,
  input logic                 link_left,
  input logic                 link_up,
  input logic                 end_of_frame
);

  logic                 seen_r;
  logic                 after_eof_r;
  logic [PIX_IDX_W-1:0] last_idx_r;
  logic                 out_fire;
  logic                 out_stall;
  logic                 idx_zero;
  logic                 idx_next;
  logic                 any_link;

  assign out_fire  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign idx_zero  = (pixel_index == '0);
  assign idx_next  = (pixel_index == last_idx_r + 1'b1);
  assign any_link  = link_left || link_up;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      after_eof_r <= 1'b0;
    end else if (out_fire) begin
      seen_r      <= 1'b1;
      after_eof_r <= end_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      last_idx_r <= pixel_index;
    end
  end

  `DGNL_ASSERT_IMP(a_idle_out_ready, !out_valid, in_ready, "input blocked with output empty")
  `DGNL_ASSERT_IMP(a_frame_restart, out_valid && after_eof_r, idx_zero, "frame did not restart")
  `DGNL_ASSERT_IMP(a_idx_step, out_valid && seen_r, idx_next || idx_zero, "pixel index skipped")
  `DGNL_ASSERT_IMP(a_first_no_link, out_valid && idx_zero, !any_link, "link on first pixel")
  `DGNL_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(pixel_index), "stalled item changed")

endmodule

bind depth_grid_neighbour_links_core dgnl_checker u_dgnl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .pixel_index  (out_chan.pixel_index),
  .link_left    (out_chan.link_left),
  .link_up      (out_chan.link_up),
  .end_of_frame (out_chan.end_of_frame)
);

FILE: dv/depth_grid_neighbour_links_core_tb.sv
module depth_grid_neighbour_links_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dgnl_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PAD_LIMIT      = 64;
  localparam int DRAIN_EVERY    = 257;

  typedef struct packed {
    logic [PIX_IDX_W-1:0] pixel_index;
    logic                 link_left;
    logic                 link_up;
    logic                 end_of_frame;
  } link_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  dgnl_in_if  in_if ();
  dgnl_out_if out_if ();

  depth_grid_neighbour_links_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mirror of the block state
  logic [CFG_SIZE_W-1:0] width_reg  = CFG_SIZE_W'(WIDTH_RESET);
  logic [CFG_SIZE_W-1:0] height_reg = CFG_SIZE_W'(HEIGHT_RESET);
  int unsigned           col_pos    = 0;
  int unsigned           row_pos    = 0;
  logic [PIX_IDX_W-1:0]  pix_count  = '0;
  logic [IN_DEPTH_W-1:0] last_depth = '0;
  logic [IN_DEPTH_W-1:0] row_above [DEF_MAX_WIDTH];
  bit                    row_above_set [DEF_MAX_WIDTH];

  link_result_t          links_due [$];
  logic [IN_DEPTH_W-1:0] depth_q [$];
  logic [IN_DEPTH_W-1:0] depth_hist [$];

  int  items_queued  = 0;
  int  items_taken   = 0;
  int  items_driven  = 0;
  int  mismatches    = 0;
  int  quiet_cycles  = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  in_taken      = 1'b0;
  bit  out_taken     = 1'b0;
  bit  hold_drain    = 1'b0;
  link_result_t want_res;
  link_result_t new_res;

  function automatic int unsigned clamp_dim(logic [CFG_SIZE_W-1:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic depth_links(logic [IN_DEPTH_W-1:0] a, logic [IN_DEPTH_W-1:0] b);
    int unsigned diff;
    int unsigned sum;
    if (a == '0 || b == '0) return 1'b0;
    diff = (a > b) ? 32'(a - b) : 32'(b - a);
    sum  = 32'(a) + 32'(b);
    return (diff * LINK_FACTOR <= sum);
  endfunction

  task automatic predict_links(input logic [IN_DEPTH_W-1:0] d, output link_result_t r);
    int unsigned w;
    int unsigned h;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) begin
      row_pos   = 0;
      col_pos   = 0;
      pix_count = '0;
    end
    r.pixel_index  = pix_count;
    r.link_left    = (col_pos > 0) ? depth_links(d, last_depth) : 1'b0;
    r.link_up      = (row_pos > 0) ? depth_links(d, row_above[col_pos]) : 1'b0;
    r.end_of_frame = (col_pos == w - 1 && row_pos == h - 1);
    row_above[col_pos]     = d;
    row_above_set[col_pos] = 1'b1;
    last_depth             = d;
    if (r.end_of_frame) begin
      col_pos   = 0;
      row_pos   = 0;
      pix_count = '0;
    end else begin
      pix_count++;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h (result %0d)",
             what, got, want, items_taken);
    mismatches++;
  endtask

  // scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken  = in_if.valid && in_if.ready;
      out_taken = out_if.valid && out_if.ready;
      if (out_taken) begin
        if (links_due.size() == 0) begin
          flag_mismatch("unexpected item", out_if.pixel_index, 0);
        end else begin
          want_res = links_due.pop_front();
          if (out_if.pixel_index !== want_res.pixel_index)
            flag_mismatch("pixel_index", out_if.pixel_index, want_res.pixel_index);
          if (out_if.link_left !== want_res.link_left)
            flag_mismatch("link_left", out_if.link_left, want_res.link_left);
          if (out_if.link_up !== want_res.link_up)
            flag_mismatch("link_up", out_if.link_up, want_res.link_up);
          if (out_if.end_of_frame !== want_res.end_of_frame)
            flag_mismatch("end_of_frame", out_if.end_of_frame, want_res.end_of_frame);
        end
      end
      if (in_taken) begin
        predict_links(in_if.depth, new_res);
        links_due = {links_due, new_res};
        items_taken++;
      end
      if (in_taken || out_taken || (items_taken == items_queued && links_due.size() == 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no progress for %0d cycles", quiet_cycles);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // depth driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!(in_if.valid && !in_taken)) begin
      if (hold_drain && links_due.size() == 0) hold_drain = 1'b0;
      if (!hold_drain && depth_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.depth <= depth_q.pop_front();
        in_if.valid <= 1'b1;
        items_driven++;
        if (items_driven % DRAIN_EVERY == 100) hold_drain = 1'b1;
      end else begin
        in_if.valid <= 1'b0;
        in_if.depth <= IN_DEPTH_W'($urandom);
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic [IN_DEPTH_W-1:0] near_depth(int unsigned base);
    int unsigned span;
    int unsigned delta;
    int          v;
    if (base == 0) base = $urandom_range(1, 65535);
    span  = base / 19 + 1;
    delta = $urandom_range(0, span);
    v = $urandom_range(0, 1) ? int'(base) + int'(delta) : int'(base) - int'(delta);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[IN_DEPTH_W-1:0];
  endfunction

  // mix of holes, saturation, near-neighbour values and noise
  function automatic logic [IN_DEPTH_W-1:0] pick_depth();
    int unsigned sel;
    int unsigned base;
    int unsigned w;
    sel = $urandom_range(0, 99);
    w   = clamp_dim(width_reg, DEF_MAX_WIDTH);
    if (sel < 5) return '0;
    if (sel < 8) return '1;
    if (sel < 10) return IN_DEPTH_W'(1);
    if (sel < 70) begin
      if (sel < 40 || depth_hist.size() < w)
        base = (depth_hist.size() != 0) ? depth_hist[$] : 0;
      else
        base = depth_hist[depth_hist.size() - w];
      return near_depth(base);
    end
    return IN_DEPTH_W'($urandom_range(0, 65535));
  endfunction

  task automatic push_depth(input logic [IN_DEPTH_W-1:0] d);
    depth_q    = {depth_q, d};
    depth_hist = {depth_hist, d};
    if (depth_hist.size() > DEF_MAX_WIDTH + 8) void'(depth_hist.pop_front());
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || links_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [CFG_SIZE_W-1:0] val);
    logic [CFG_DATA_W-1:0] wdata;
    wdata = $urandom;
    wdata[CFG_SIZE_W-1:0] = val;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (sel == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {{(CFG_DATA_W - CFG_SIZE_W){1'b0}}, val})
      flag_mismatch(sel == REG_FRAME_WIDTH ? "frame_width readback" : "frame_height readback",
                    cfg_prdata, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // a new width must never make the up test read a column not yet written
  function automatic bit width_safe(int unsigned nw);
    int unsigned c;
    int unsigned r;
    if (row_pos == 0) return 1'b1;
    c = col_pos;
    r = row_pos;
    if (c >= nw) begin
      c = 0;
      r++;
    end
    if (r >= clamp_dim(height_reg, DEF_MAX_HEIGHT)) return 1'b1;
    for (int i = 0; i < nw; i++) begin
      if (!row_above_set[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int frame_rest();
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) return 0;
    return int'((h - r) * w - c);
  endfunction

  task automatic run_phase(input logic [CFG_SIZE_W-1:0] nw, input logic [CFG_SIZE_W-1:0] nh,
                           input bit set_w, input bit set_h, input int n);
    int rest;
    bit do_w;
    do_w = set_w;
    if (do_w && !width_safe(clamp_dim(nw, DEF_MAX_WIDTH))) begin
      rest = frame_rest();
      if (rest <= PAD_LIMIT) begin
        for (int i = 0; i < rest; i++) push_depth(pick_depth());
        wait_idle();
      end else begin
        do_w = 1'b0;
      end
    end
    if (do_w) write_reg(REG_FRAME_WIDTH, nw);
    if (set_h) write_reg(REG_FRAME_HEIGHT, nh);
    for (int i = 0; i < n; i++) push_depth(pick_depth());
    wait_idle();
  endtask

  task automatic run_random(input int target);
    int                    sent;
    int                    n;
    int unsigned           pick;
    logic [CFG_SIZE_W-1:0] w;
    logic [CFG_SIZE_W-1:0] h;
    bit                    sw;
    bit                    sh;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 7) == 0) w = CFG_SIZE_W'($urandom_range(0, 1));
      else w = CFG_SIZE_W'($urandom_range(2, 24));
      pick = $urandom_range(0, 9);
      if (pick == 0) h = CFG_SIZE_W'($urandom_range(0, 1));
      else if (pick == 1) h = CFG_SIZE_W'($urandom_range(1025, 2047));
      else h = CFG_SIZE_W'($urandom_range(2, 8));
      sw = ($urandom_range(0, 4) != 0);
      sh = !sw || ($urandom_range(0, 4) != 0);
      n  = $urandom_range(10, 40);
      run_phase(w, h, sw, sh, n);
      sent += n;
    end
  endtask

  initial begin
    logic [IN_DEPTH_W-1:0] opening_vals [5];
    logic [IN_DEPTH_W-1:0] corner_vals [16];
    opening_vals = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'h7FFF};
    // exact link bound, just past it, holes, saturation at both ends of the range
    corner_vals  = '{16'd21, 16'd19, 16'd22, 16'hFFFF,
                     16'd0, 16'd19, 16'd59294, 16'hFFFF,
                     16'd1, 16'd1, 16'd59293, 16'hFFFF,
                     16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_if.valid  = 1'b0;
    in_if.depth  = '0;
    out_if.ready = 1'b0;

    send_idle_pct = 7;
    recv_idle_pct = 55;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset sizes first, then a small frame with the directed values
    foreach (opening_vals[i]) push_depth(opening_vals[i]);
    wait_idle();
    run_phase(CFG_SIZE_W'(4), CFG_SIZE_W'(3), 1'b1, 1'b1, 0);
    foreach (corner_vals[i]) push_depth(corner_vals[i]);
    wait_idle();
    run_phase(CFG_SIZE_W'(0), CFG_SIZE_W'(1), 1'b1, 1'b1, 20);
    run_phase(CFG_SIZE_W'(7), CFG_SIZE_W'(5), 1'b1, 1'b1, 35);
    run_random(40);

    send_idle_pct = 55;
    recv_idle_pct = 7;
    run_phase(CFG_SIZE_W'(16), CFG_SIZE_W'(2047), 1'b1, 1'b1, 40);
    run_phase(CFG_SIZE_W'(3), CFG_SIZE_W'(9), 1'b1, 1'b1, 27);
    run_random(40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(CFG_SIZE_W'(2), CFG_SIZE_W'(2), 1'b1, 1'b1, 9);
    run_phase(CFG_SIZE_W'(2047), CFG_SIZE_W'(2), 1'b1, 1'b1, 1028);
    run_phase(CFG_SIZE_W'(5), CFG_SIZE_W'(0), 1'b1, 1'b1, 10);
    run_phase(CFG_SIZE_W'(1024), CFG_SIZE_W'(2), 1'b1, 1'b0, 10);
    run_random(10);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/dgnl_pkg.sv
hw/rtl/dgnl_in_if.sv
hw/rtl/dgnl_out_if.sv
hw/rtl/dgnl_link.sv
hw/rtl/depth_grid_neighbour_links_core.sv
hw/rtl/dgnl_checker.sv
dv/depth_grid_neighbour_links_core_tb.sv
